// ===== hdl/crru_pkg.sv =====
package crru_pkg;

    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_CALL_NZ  = 8'hC4;
    localparam logic [7:0] OP_CALL_Z   = 8'hCC;
    localparam logic [7:0] OP_CALL_NC  = 8'hD4;
    localparam logic [7:0] OP_CALL_C   = 8'hDC;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_RET_NZ   = 8'hC0;
    localparam logic [7:0] OP_RET_Z    = 8'hC8;
    localparam logic [7:0] OP_RET_NC   = 8'hD0;
    localparam logic [7:0] OP_RET_C    = 8'hD8;
    localparam logic [7:0] OP_RETI     = 8'hD9;
    localparam logic [7:0] OP_RST_BASE = 8'hC7;
    localparam logic [7:0] OP_RST_MASK = 8'hC7;
    localparam logic [7:0] RST_VECTOR_MASK = 8'h38;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_CALL = 3'd1;
    localparam logic [2:0] KIND_RST  = 3'd2;
    localparam logic [2:0] KIND_RET  = 3'd3;
    localparam logic [2:0] KIND_RETI = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic       cond;
    } dec_t;

    typedef struct packed {
        logic capture;
        logic push;
        logic pop;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic do_push;
        logic do_pop;
        logic out_free;
    } sts_t;

    function automatic dec_t decode(input logic [7:0] op, input logic z, input logic c);
        dec_t d;
        d.kind = KIND_NONE;
        d.cond = 1'b1;
        case (op)
            OP_CALL:    d.kind = KIND_CALL;
            OP_CALL_NZ: begin d.kind = KIND_CALL; d.cond = ~z; end
            OP_CALL_Z:  begin d.kind = KIND_CALL; d.cond = z;  end
            OP_CALL_NC: begin d.kind = KIND_CALL; d.cond = ~c; end
            OP_CALL_C:  begin d.kind = KIND_CALL; d.cond = c;  end
            OP_RET:     d.kind = KIND_RET;
            OP_RET_NZ:  begin d.kind = KIND_RET; d.cond = ~z; end
            OP_RET_Z:   begin d.kind = KIND_RET; d.cond = z;  end
            OP_RET_NC:  begin d.kind = KIND_RET; d.cond = ~c; end
            OP_RET_C:   begin d.kind = KIND_RET; d.cond = c;  end
            OP_RETI:    d.kind = KIND_RETI;
            default:
            begin
                if ((op & OP_RST_MASK) == OP_RST_BASE)
                    d.kind = KIND_RST;
            end
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/crru_ctrl.sv =====
module crru_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  crru_pkg::sts_t sts,
    output crru_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.push    = 1'b0;
        cmd.pop     = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.push   = sts.do_push;
                cmd.pop    = sts.do_pop;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/crru_dp.sv =====
module crru_dp #(
    parameter int STACK_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     opcode_byte,
    input  logic [15:0]    target_address,
    input  logic [15:0]    return_address,
    input  logic           zero_flag,
    input  logic           carry_flag,
    input  logic [7:0]     cycles_if_taken,
    input  logic [7:0]     cycles_if_skipped,
    input  crru_pkg::cmd_t cmd,
    output crru_pkg::sts_t sts,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [15:0]    next_pc,
    output logic           branch_taken,
    output logic [7:0]     cycle_count,
    output logic           illegal_opcode,
    output logic           enable_interrupts
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STACK_DEPTH - 1);

    logic [15:0] stack_mem [STACK_DEPTH];

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_dec;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [15:0] pc_reg;
    logic [15:0] push_data_reg;
    logic [15:0] rd_data_reg;
    logic        taken_reg;
    logic [7:0]  cyc_reg;
    logic        ill_reg;
    logic        ei_reg;
    logic        push_reg;
    logic        pop_reg;

    logic [15:0] out_pc_reg;
    logic        out_taken_reg;
    logic [7:0]  out_cyc_reg;
    logic        out_ill_reg;
    logic        out_ei_reg;

    crru_pkg::dec_t dec;
    logic           legal;
    logic           go;
    logic           is_call;
    logic           is_rst;
    logic           is_ret;

    always_comb
    begin
        dec     = crru_pkg::decode(opcode_byte, zero_flag, carry_flag);
        legal   = (dec.kind != crru_pkg::KIND_NONE);
        go      = legal && dec.cond;
        is_call = (dec.kind == crru_pkg::KIND_CALL);
        is_rst  = (dec.kind == crru_pkg::KIND_RST);
        is_ret  = (dec.kind == crru_pkg::KIND_RET) || (dec.kind == crru_pkg::KIND_RETI);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (go && is_call)
                pc_reg <= target_address;
            else if (go && is_rst)
                pc_reg <= {8'h00, opcode_byte & crru_pkg::RST_VECTOR_MASK};
            else
                pc_reg <= return_address;
            push_data_reg <= return_address;
            taken_reg     <= go;
            cyc_reg       <= !legal ? 8'h00 : (go ? cycles_if_taken : cycles_if_skipped);
            ill_reg       <= !legal;
            ei_reg        <= go && (dec.kind == crru_pkg::KIND_RETI);
            push_reg      <= go && (is_call || is_rst);
            pop_reg       <= go && is_ret;
        end
    end

    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_dec = (idx_reg == '0) ? IDX_LAST : idx_reg - 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.push)
            idx_next = idx_inc;
        else if (cmd.pop)
            idx_next = idx_dec;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[idx_reg] <= push_data_reg;
        if (cmd.pop)
            rd_data_reg <= stack_mem[idx_dec];
    end

    assign sts.do_push  = push_reg;
    assign sts.do_pop   = pop_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_pc_reg    <= pop_reg ? rd_data_reg : pc_reg;
            out_taken_reg <= taken_reg;
            out_cyc_reg   <= cyc_reg;
            out_ill_reg   <= ill_reg;
            out_ei_reg    <= ei_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign next_pc           = out_pc_reg;
    assign branch_taken      = out_taken_reg;
    assign cycle_count       = out_cyc_reg;
    assign illegal_opcode    = out_ill_reg;
    assign enable_interrupts = out_ei_reg;

endmodule

// ===== hdl/call_return_restart_unit.sv =====
// Channel  Direction  Handshake            Beat
// input    in         in_valid / in_stall   opcode, addresses, flags, cycle counts
// output   out        out_valid / out_stall next_pc, branch_taken, cycle_count, flags
//
// Each instruction passes through capture and decode, stack access and result load, in that order.
// The return stack is one memory with a registered read port; a pop waits for that read.
// The next beat is taken while a finished result still waits on out_stall.
// Reset clears the stack pointer and the output valid; stack contents stay undefined.
// out_stall holds only the output register; the core stalls once a second result is ready.
module call_return_restart_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode_byte,
    input  logic [15:0] target_address,
    input  logic [15:0] return_address,
    input  logic        zero_flag,
    input  logic        carry_flag,
    input  logic [7:0]  cycles_if_taken,
    input  logic [7:0]  cycles_if_skipped,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        branch_taken,
    output logic [7:0]  cycle_count,
    output logic        illegal_opcode,
    output logic        enable_interrupts
);

    crru_pkg::cmd_t cmd;
    crru_pkg::sts_t sts;

    crru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    crru_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .opcode_byte       (opcode_byte),
        .target_address    (target_address),
        .return_address    (return_address),
        .zero_flag         (zero_flag),
        .carry_flag        (carry_flag),
        .cycles_if_taken   (cycles_if_taken),
        .cycles_if_skipped (cycles_if_skipped),
        .cmd               (cmd),
        .sts               (sts),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .next_pc           (next_pc),
        .branch_taken      (branch_taken),
        .cycle_count       (cycle_count),
        .illegal_opcode    (illegal_opcode),
        .enable_interrupts (enable_interrupts)
    );

    a_single_stack_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second beat taken while an item is in flight");

    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal_opcode) |-> (!branch_taken && cycle_count == 8'h00
                                            && !enable_interrupts))
        else $error("illegal opcode reported with a branch or cycles");

    a_ei_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && enable_interrupts) |-> branch_taken)
        else $error("interrupt enable without a taken return");

endmodule
